// ===== rtl/dtse_pkg.sv =====
// Shared types, field codes and calendar helpers for the date and time set editor.
`default_nettype none

package dtse_pkg;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned FIELD_W  = 3;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SELECT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INC    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEC    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SAVE   = 3'd4;

   // Field codes.
   localparam logic [FIELD_W-1:0] FIELD_DAY    = 3'd0;
   localparam logic [FIELD_W-1:0] FIELD_MONTH  = 3'd1;
   localparam logic [FIELD_W-1:0] FIELD_YEAR   = 3'd2;
   localparam logic [FIELD_W-1:0] FIELD_HOUR   = 3'd3;
   localparam logic [FIELD_W-1:0] FIELD_MINUTE = 3'd4;
   localparam logic [FIELD_W-1:0] FIELD_SECOND = 3'd5;

   localparam logic [YEAR_W-1:0]   YEAR_FIRST  = 12'd2000;
   localparam logic [YEAR_W-1:0]   YEAR_LAST   = 12'd2099;
   localparam logic [YEAR_W-1:0]   YEAR_RESET  = 12'd2026;
   localparam logic [DAY_W-1:0]    DAY_RESET   = 5'd1;
   localparam logic [MONTH_W-1:0]  MONTH_RESET = 4'd1;
   localparam logic [HOUR_W-1:0]   HOUR_RESET  = 5'd12;
   localparam logic [MONTH_W-1:0]  MONTH_MAX   = 4'd12;
   localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX  = 6'd59;

   // Reciprocal for the year / 100 quotient, exact for every 12-bit year.
   localparam int unsigned DIV100_SHIFT = 19;
   localparam int unsigned DIV100_MUL   = (1 << DIV100_SHIFT) / 100 + 1;
   localparam int unsigned DIV100_PW    = YEAR_W + 13;
   localparam int unsigned CENT_W       = DIV100_PW - DIV100_SHIFT;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [FIELD_W-1:0]  field;
   } clock_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [FIELD_W-1:0]  field_sel;
      logic [DAY_W-1:0]    load_day;
      logic [MONTH_W-1:0]  load_month;
      logic [YEAR_W-1:0]   load_year;
      logic [HOUR_W-1:0]   load_hour;
      logic [MINUTE_W-1:0] load_minute;
      logic [SECOND_W-1:0] load_second;
   } edit_req_type;

   typedef struct packed {
      clock_state_type state;
      logic            write_strobe;
   } edit_rsp_type;

   // Gregorian rule: divisible by 4, except centuries not divisible by 400.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [DIV100_PW-1:0] prod;
      logic [CENT_W-1:0]    cent;
      logic [YEAR_W:0]      cent_x100;
      logic                 div100;
      prod      = DIV100_PW'(year) * DIV100_PW'(DIV100_MUL);
      cent      = prod[DIV100_PW-1:DIV100_SHIFT];
      cent_x100 = (YEAR_W+1)'(cent) * (YEAR_W+1)'(100);
      div100    = (cent_x100 == {1'b0, year});
      return (year[1:0] == 2'd0) && (!div100 || (cent[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic [YEAR_W-1:0]  year);
      logic [DAY_W-1:0] len;
      if (month == 4'd2) begin
         len = is_leap(year) ? 5'd29 : 5'd28;
      end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dtse_if.sv =====
// Valid/ready channel interfaces for the editor's request and response sides.
`default_nettype none

interface dtse_req_if import dtse_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [FIELD_W-1:0]  field_sel;
   logic [DAY_W-1:0]    load_day;
   logic [MONTH_W-1:0]  load_month;
   logic [YEAR_W-1:0]   load_year;
   logic [HOUR_W-1:0]   load_hour;
   logic [MINUTE_W-1:0] load_minute;
   logic [SECOND_W-1:0] load_second;

   modport source (
      output valid, kind, field_sel, load_day, load_month, load_year,
             load_hour, load_minute, load_second,
      input  ready
   );
   modport sink (
      input  valid, kind, field_sel, load_day, load_month, load_year,
             load_hour, load_minute, load_second,
      output ready
   );
endinterface

interface dtse_rsp_if import dtse_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DAY_W-1:0]    out_day;
   logic [MONTH_W-1:0]  out_month;
   logic [YEAR_W-1:0]   out_year;
   logic [HOUR_W-1:0]   out_hour;
   logic [MINUTE_W-1:0] out_minute;
   logic [SECOND_W-1:0] out_second;
   logic [FIELD_W-1:0]  selected;
   logic                write_strobe;

   modport source (
      output valid, out_day, out_month, out_year, out_hour, out_minute,
             out_second, selected, write_strobe,
      input  ready
   );
   modport sink (
      input  valid, out_day, out_month, out_year, out_hour, out_minute,
             out_second, selected, write_strobe,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/dtse_edit.sv =====
// Next-state logic: applies one edit request to the held date and time.
`default_nettype none

module dtse_edit import dtse_pkg::*; (
   input  clock_state_type cur,
   input  edit_req_type    req,
   output clock_state_type nxt,
   output logic            write_strobe
);

   logic [MONTH_W-1:0]  ld_month;
   logic [YEAR_W-1:0]   ld_year;
   logic [DAY_W-1:0]    ld_len;
   logic [DAY_W-1:0]    ld_day;
   logic [HOUR_W-1:0]   ld_hour;
   logic [MINUTE_W-1:0] ld_minute;
   logic [SECOND_W-1:0] ld_second;

   logic                up;
   logic [DAY_W-1:0]    cur_len;
   logic [DAY_W-1:0]    st_day;
   logic [MONTH_W-1:0]  st_month;
   logic [DAY_W-1:0]    st_month_len;
   logic [DAY_W-1:0]    st_month_day;
   logic [YEAR_W-1:0]   st_year;
   logic [HOUR_W-1:0]   st_hour;
   logic [MINUTE_W-1:0] st_minute;
   logic [SECOND_W-1:0] st_second;

   // Load path: saturate each value, then clamp the day to the loaded month.
   always_comb begin
      if (req.load_month == '0) begin
         ld_month = MONTH_RESET;
      end else if (req.load_month > MONTH_MAX) begin
         ld_month = MONTH_MAX;
      end else begin
         ld_month = req.load_month;
      end
      if (req.load_year < YEAR_FIRST) begin
         ld_year = YEAR_FIRST;
      end else if (req.load_year > YEAR_LAST) begin
         ld_year = YEAR_LAST;
      end else begin
         ld_year = req.load_year;
      end
      ld_len = month_length(ld_month, ld_year);
      if (req.load_day == '0) begin
         ld_day = DAY_RESET;
      end else if (req.load_day > ld_len) begin
         ld_day = ld_len;
      end else begin
         ld_day = req.load_day;
      end
      ld_hour   = (req.load_hour > HOUR_MAX) ? HOUR_MAX : req.load_hour;
      ld_minute = (req.load_minute > MINUTE_MAX) ? MINUTE_MAX : req.load_minute;
      ld_second = (req.load_second > SECOND_MAX) ? SECOND_MAX : req.load_second;
   end

   // Step path: every field's wrapped neighbor is formed, the selection picks one.
   always_comb begin
      up      = (req.kind == KIND_INC);
      cur_len = month_length(cur.month, cur.year);
      if (up) begin
         st_day    = (cur.day >= cur_len) ? DAY_RESET : cur.day + 5'd1;
         st_month  = (cur.month >= MONTH_MAX) ? MONTH_RESET : cur.month + 4'd1;
         st_year   = (cur.year >= YEAR_LAST) ? YEAR_FIRST : cur.year + 12'd1;
         st_hour   = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + 5'd1;
         st_minute = (cur.minute >= MINUTE_MAX) ? '0 : cur.minute + 6'd1;
         st_second = (cur.second >= SECOND_MAX) ? '0 : cur.second + 6'd1;
      end else begin
         st_day    = (cur.day <= DAY_RESET) ? cur_len : cur.day - 5'd1;
         st_month  = (cur.month <= MONTH_RESET) ? MONTH_MAX : cur.month - 4'd1;
         st_year   = (cur.year <= YEAR_FIRST) ? YEAR_LAST : cur.year - 12'd1;
         st_hour   = (cur.hour == '0) ? HOUR_MAX : cur.hour - 5'd1;
         st_minute = (cur.minute == '0) ? MINUTE_MAX : cur.minute - 6'd1;
         st_second = (cur.second == '0) ? SECOND_MAX : cur.second - 6'd1;
      end
      st_month_len = month_length(st_month, cur.year);
      st_month_day = (cur.day > st_month_len) ? st_month_len : cur.day;
   end

   always_comb begin
      nxt          = cur;
      write_strobe = 1'b0;
      case (req.kind)
         KIND_LOAD: begin
            nxt.day    = ld_day;
            nxt.month  = ld_month;
            nxt.year   = ld_year;
            nxt.hour   = ld_hour;
            nxt.minute = ld_minute;
            nxt.second = ld_second;
         end
         KIND_SELECT: begin
            if (req.field_sel <= FIELD_SECOND) begin
               nxt.field = req.field_sel;
            end
         end
         KIND_INC, KIND_DEC: begin
            case (cur.field)
               FIELD_DAY:    nxt.day = st_day;
               FIELD_MONTH: begin
                  nxt.month = st_month;
                  nxt.day   = st_month_day;
               end
               FIELD_YEAR:   nxt.year = st_year;
               FIELD_HOUR:   nxt.hour = st_hour;
               FIELD_MINUTE: nxt.minute = st_minute;
               FIELD_SECOND: nxt.second = st_second;
               default:      nxt = cur;
            endcase
         end
         KIND_SAVE:    write_strobe = 1'b1;
         default:      nxt = cur;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/date_time_set_editor_top.sv =====
// Top level of the date and time set editor: request register, held state, response register.
//
//   Channel  Dir  Signals
//   req_ch   in   valid/ready; kind, field_sel, load_day .. load_second
//   rsp_ch   out  valid/ready; out_day .. out_second, selected, write_strobe
//
// One request in, one response out. A request is registered on its transfer and
// applied to the held date and time once the response register can advance, and the
// response register is loaded at the same time; one request per cycle while responses are taken.
// Synchronous reset loads 1 Jan 2026 12:00:00 with the day field selected.
// A response that is not taken holds both stages; req_ch.ready falls only when
// both the request and response registers are full and rsp_ch.ready is low.
`default_nettype none

module date_time_set_editor_top import dtse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dtse_req_if.sink   req_ch,
   dtse_rsp_if.source rsp_ch
);

   logic            req_valid_ff;
   edit_req_type    req_item_ff;
   edit_req_type    req_item_in;
   clock_state_type state_ff;
   clock_state_type state_in;
   logic            strobe_in;
   logic            rsp_valid_ff;
   edit_rsp_type    rsp_ff;
   logic            advance;
   logic            fire;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_valid_ff && advance;
   assign req_ch.ready = !req_valid_ff || advance;

   assign req_item_in = '{
      kind:        req_ch.kind,
      field_sel:   req_ch.field_sel,
      load_day:    req_ch.load_day,
      load_month:  req_ch.load_month,
      load_year:   req_ch.load_year,
      load_hour:   req_ch.load_hour,
      load_minute: req_ch.load_minute,
      load_second: req_ch.load_second
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         req_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_item_ff <= req_item_in;
      end
   end

   dtse_edit u_edit (
      .cur          (state_ff),
      .req          (req_item_ff),
      .nxt          (state_in),
      .write_strobe (strobe_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{
            day:    DAY_RESET,
            month:  MONTH_RESET,
            year:   YEAR_RESET,
            hour:   HOUR_RESET,
            minute: '0,
            second: '0,
            field:  FIELD_DAY
         };
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff.state        <= state_in;
         rsp_ff.write_strobe <= strobe_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_day      = rsp_ff.state.day;
   assign rsp_ch.out_month    = rsp_ff.state.month;
   assign rsp_ch.out_year     = rsp_ff.state.year;
   assign rsp_ch.out_hour     = rsp_ff.state.hour;
   assign rsp_ch.out_minute   = rsp_ff.state.minute;
   assign rsp_ch.out_second   = rsp_ff.state.second;
   assign rsp_ch.selected     = rsp_ff.state.field;
   assign rsp_ch.write_strobe = rsp_ff.write_strobe;

endmodule

`default_nettype wire
